// ===== hw/rtl/scfu_pkg.sv =====
// ----------------------------------------------------------------------------
// scfu_pkg
// Shared types, constants and helper functions of the spherical camera unit.
// ----------------------------------------------------------------------------
package scfu_pkg;

	// number formats
	localparam int ANG_BITS          = 20;  // angle width, fraction of a turn
	localparam int CORDIC_ITERATIONS = 18;  // rotation steps per sine/cosine
	localparam int ITER_W            = 5;   // indexes the 32-entry arctangent table
	localparam int CW                = 34;  // CORDIC x/y/z datapath width (Q30 + margin)
	localparam int DIR_W             = 18;  // Q1.16 direction component
	localparam int POS_W             = 32;  // Q16.16 coordinate
	localparam int SUM_W             = 35;  // coordinate sums before saturation
	localparam int MUL_A_W           = 32;
	localparam int PROD_W            = 50;  // 32 x 18 signed product
	localparam int DD_W              = 34;  // rounded product, Q16.16 with headroom
	localparam int STEP_W            = 20;  // angle step and start angle registers
	localparam int MSTEP_W           = 31;
	localparam int CFG_W             = 32;
	localparam int CFG_IDX_W         = 3;

	localparam logic signed [CW-1:0]    CORDIC_GAIN = 34'sd652032874;
	localparam logic signed [DIR_W-1:0] Q16_ONE     = 18'sd65536;

	// register reset values
	localparam logic [STEP_W-1:0]       THETA_STEP_RST  = 20'd16689;
	localparam logic [STEP_W-1:0]       BETA_STEP_RST   = 20'd16689;
	localparam logic [MSTEP_W-1:0]      MOVE_STEP_RST   = 31'd458752;
	localparam logic signed [POS_W-1:0] START_X_RST     = 32'sd0;
	localparam logic signed [POS_W-1:0] START_Y_RST     = 32'sd1310720;
	localparam logic signed [POS_W-1:0] START_Z_RST     = 32'sd4587520;
	localparam logic [STEP_W-1:0]       START_THETA_RST = 20'd784519;
	localparam logic [STEP_W-1:0]       START_BETA_RST  = 20'd269979;

	// action codes
	localparam logic [1:0] ACT_ORIENT  = 2'd0;
	localparam logic [1:0] ACT_MOVE    = 2'd1;
	localparam logic [1:0] ACT_RESTART = 2'd2;

	// configuration register indexes
	typedef enum logic [CFG_IDX_W-1:0] {
		REG_THETA_STEP  = 3'd0,
		REG_BETA_STEP   = 3'd1,
		REG_MOVE_STEP   = 3'd2,
		REG_START_X     = 3'd3,
		REG_START_Y     = 3'd4,
		REG_START_Z     = 3'd5,
		REG_START_THETA = 3'd6,
		REG_START_BETA  = 3'd7
	} cfg_reg_t;

	// sequencer states
	typedef enum logic [3:0] {
		ST_IDLE,
		ST_START_TH,
		ST_RUN_TH,
		ST_RUN_BE,
		ST_DIR_X,
		ST_DIR_Z,
		ST_DIR_W,
		ST_MOV_X,
		ST_MOV_Y,
		ST_MOV_Z,
		ST_MOV_W,
		ST_DONE
	} state_t;

	// sine/cosine unit handshake
	typedef struct packed {
		logic                start;
		logic [ANG_BITS-1:0] angle;
	} cordic_req_t;

	typedef struct packed {
		logic                    done;
		logic signed [DIR_W-1:0] sin;
		logic signed [DIR_W-1:0] cos;
	} cordic_rsp_t;

	// arctangent of 2^-i in 2^-32 turns
	function automatic logic [31:0] atan_turn(input logic [ITER_W-1:0] i);
		logic [31:0] r;
		case (i)
			5'd0:    r = 32'h20000000;
			5'd1:    r = 32'h12E4051E;
			5'd2:    r = 32'h09FB385B;
			5'd3:    r = 32'h051111D4;
			5'd4:    r = 32'h028B0D43;
			5'd5:    r = 32'h0145D7E1;
			5'd6:    r = 32'h00A2F61E;
			5'd7:    r = 32'h00517C55;
			5'd8:    r = 32'h0028BE53;
			5'd9:    r = 32'h00145F2F;
			5'd10:   r = 32'h000A2F98;
			5'd11:   r = 32'h000517CC;
			5'd12:   r = 32'h00028BE6;
			5'd13:   r = 32'h000145F3;
			5'd14:   r = 32'h0000A2FA;
			5'd15:   r = 32'h0000517D;
			5'd16:   r = 32'h000028BE;
			5'd17:   r = 32'h0000145F;
			5'd18:   r = 32'h00000A30;
			5'd19:   r = 32'h00000518;
			5'd20:   r = 32'h0000028C;
			5'd21:   r = 32'h00000146;
			5'd22:   r = 32'h000000A3;
			5'd23:   r = 32'h00000051;
			5'd24:   r = 32'h00000029;
			5'd25:   r = 32'h00000014;
			5'd26:   r = 32'h0000000A;
			5'd27:   r = 32'h00000005;
			5'd28:   r = 32'h00000003;
			5'd29:   r = 32'h00000001;
			5'd30:   r = 32'h00000001;
			default: r = 32'h00000000;
		endcase
		return r;
	endfunction

	// clamp a widened sum to the signed 32-bit range
	function automatic logic signed [POS_W-1:0] sat32(input logic signed [SUM_W-1:0] v);
		logic signed [POS_W-1:0] r;
		if (v > SUM_W'(32'sh7FFFFFFF))
			r = 32'sh7FFFFFFF;
		else if (v < -SUM_W'(33'sh080000000))
			r = 32'sh80000000;
		else
			r = v[POS_W-1:0];
		return r;
	endfunction

	// fit a 20-bit register value to the angle width (truncate or zero-extend)
	function automatic logic [ANG_BITS-1:0] angle_fit(input logic [STEP_W-1:0] v);
		logic [ANG_BITS+STEP_W-1:0] w;
		w = {{ANG_BITS{1'b0}}, v};
		return w[ANG_BITS-1:0];
	endfunction

endpackage

// ===== hw/rtl/scfu_if.sv =====
// ----------------------------------------------------------------------------
// scfu_if
// Valid/ready channels of the camera unit: command items in, view items out.
// ----------------------------------------------------------------------------
interface scfu_cmd_if;
	logic       valid;
	logic       ready;
	logic [1:0] action;
	logic       change_beta;
	logic       beta_up;
	logic       change_theta;
	logic       theta_up;
	logic       forward;

	modport source (
		output valid, action, change_beta, beta_up, change_theta, theta_up, forward,
		input  ready
	);
	modport sink (
		input  valid, action, change_beta, beta_up, change_theta, theta_up, forward,
		output ready
	);
endinterface

interface scfu_res_if;
	logic              valid;
	logic              ready;
	logic signed [31:0] eye_x;
	logic signed [31:0] eye_y;
	logic signed [31:0] eye_z;
	logic signed [31:0] center_x;
	logic signed [31:0] center_y;
	logic signed [31:0] center_z;

	modport source (
		output valid, eye_x, eye_y, eye_z, center_x, center_y, center_z,
		input  ready
	);
	modport sink (
		input  valid, eye_x, eye_y, eye_z, center_x, center_y, center_z,
		output ready
	);
endinterface

// ===== hw/rtl/scfu_cordic.sv =====
// ----------------------------------------------------------------------------
// scfu_cordic
// Iterative sine/cosine unit: one CORDIC rotation per cycle, quadrant fold.
// ----------------------------------------------------------------------------
module scfu_cordic (
	input  logic                  clk,
	input  logic                  arst_n,
	input  scfu_pkg::cordic_req_t req,
	output scfu_pkg::cordic_rsp_t rsp
);

	logic                            run_q;
	logic                            done_q;
	logic [scfu_pkg::ITER_W-1:0]     iter_q;
	logic signed [scfu_pkg::CW-1:0]  x_q;
	logic signed [scfu_pkg::CW-1:0]  y_q;
	logic signed [scfu_pkg::CW-1:0]  z_q;
	logic [1:0]                      quad_q;

	logic [31:0]                     a32;
	logic signed [scfu_pkg::CW-1:0]  xs;
	logic signed [scfu_pkg::CW-1:0]  ys;
	logic signed [scfu_pkg::CW-1:0]  at;
	logic signed [scfu_pkg::DIR_W-1:0] c_r;
	logic signed [scfu_pkg::DIR_W-1:0] s_r;

	// Q30 to Q16 with round half up, clamped to one
	function automatic logic signed [scfu_pkg::DIR_W-1:0] to_q16(
		input logic signed [scfu_pkg::CW-1:0] v
	);
		logic signed [scfu_pkg::CW-1:0] r;
		logic signed [scfu_pkg::DIR_W-1:0] o;
		r = (v + scfu_pkg::CW'(15'sd8192)) >>> 14;
		if (r > scfu_pkg::CW'(scfu_pkg::Q16_ONE))
			o = scfu_pkg::Q16_ONE;
		else if (r < -scfu_pkg::CW'(scfu_pkg::Q16_ONE))
			o = -scfu_pkg::Q16_ONE;
		else
			o = r[scfu_pkg::DIR_W-1:0];
		return o;
	endfunction

	// angle widened to a full 32-bit turn fraction; shared shifter per step
	always_comb begin
		a32 = 32'(req.angle) << (32 - scfu_pkg::ANG_BITS);
		xs  = x_q >>> iter_q;
		ys  = y_q >>> iter_q;
		at  = signed'({2'b00, scfu_pkg::atan_turn(iter_q)});
	end

	// iteration control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
			iter_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				run_q  <= 1'b1;
				iter_q <= '0;
			end else if (run_q) begin
				iter_q <= iter_q + 1'b1;
				if (iter_q == scfu_pkg::ITER_W'(scfu_pkg::CORDIC_ITERATIONS - 1)) begin
					run_q  <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// rotation datapath
	always_ff @(posedge clk) begin
		if (req.start) begin
			x_q    <= scfu_pkg::CORDIC_GAIN;
			y_q    <= '0;
			z_q    <= signed'({4'b0000, a32[29:0]});
			quad_q <= a32[31:30];
		end else if (run_q) begin
			if (z_q >= 0) begin
				x_q <= x_q - ys;
				y_q <= y_q + xs;
				z_q <= z_q - at;
			end else begin
				x_q <= x_q + ys;
				y_q <= y_q - xs;
				z_q <= z_q + at;
			end
		end
	end

	// quadrant fold of the rounded results
	always_comb begin
		c_r = to_q16(x_q);
		s_r = to_q16(y_q);
		rsp.done = done_q;
		case (quad_q)
			2'd0: begin
				rsp.cos = c_r;
				rsp.sin = s_r;
			end
			2'd1: begin
				rsp.cos = -s_r;
				rsp.sin = c_r;
			end
			2'd2: begin
				rsp.cos = -c_r;
				rsp.sin = -s_r;
			end
			default: begin
				rsp.cos = s_r;
				rsp.sin = -c_r;
			end
		endcase
	end

endmodule

// ===== hw/rtl/spherical_free_camera_update_unit.sv =====
// ----------------------------------------------------------------------------
// spherical_free_camera_update_unit
// Free-fly camera: view angles, position and sight direction, one view per item.
// ----------------------------------------------------------------------------
// Takes one command item at a time and returns one view item (eye and look-at
// point) for each. A move item steps through the states MOV_X, MOV_Y, MOV_Z
// and MOV_W before its view is loaded; an action code of 3 goes straight to
// DONE. For orient and restart items the direction is rebuilt by a single
// iterative CORDIC unit that runs 18 rotations for the polar angle and then
// 18 for the azimuth angle, followed by two passes through the shared 32x18
// multiplier. After reset the same direction pass runs once (no view item)
// before cmd.ready first rises; register writes are taken throughout. A finished
// view waits in the output register while the next command is accepted.
module spherical_free_camera_update_unit (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               wr_en,
	input  logic [scfu_pkg::CFG_IDX_W-1:0]     wr_index,
	input  logic [scfu_pkg::CFG_W-1:0]         wr_data,
	scfu_cmd_if.sink                           cmd,
	scfu_res_if.source                         res
);

	// configuration registers
	logic [scfu_pkg::STEP_W-1:0]         theta_step_q;
	logic [scfu_pkg::STEP_W-1:0]         beta_step_q;
	logic [scfu_pkg::MSTEP_W-1:0]        move_step_q;
	logic signed [scfu_pkg::POS_W-1:0]   start_x_q;
	logic signed [scfu_pkg::POS_W-1:0]   start_y_q;
	logic signed [scfu_pkg::POS_W-1:0]   start_z_q;
	logic [scfu_pkg::STEP_W-1:0]         start_theta_q;
	logic [scfu_pkg::STEP_W-1:0]         start_beta_q;

	// camera state
	scfu_pkg::state_t                    state_q;
	scfu_pkg::state_t                    state_d;
	logic                                init_q;
	logic [scfu_pkg::ANG_BITS-1:0]       polar_q;
	logic [scfu_pkg::ANG_BITS-1:0]       azim_q;
	logic signed [scfu_pkg::POS_W-1:0]   pos_x_q;
	logic signed [scfu_pkg::POS_W-1:0]   pos_y_q;
	logic signed [scfu_pkg::POS_W-1:0]   pos_z_q;
	logic signed [scfu_pkg::DIR_W-1:0]   dir_x_q;
	logic signed [scfu_pkg::DIR_W-1:0]   dir_y_q;
	logic signed [scfu_pkg::DIR_W-1:0]   dir_z_q;
	logic signed [scfu_pkg::DIR_W-1:0]   st_q;
	logic signed [scfu_pkg::DIR_W-1:0]   sb_q;
	logic signed [scfu_pkg::DIR_W-1:0]   cb_q;
	logic signed [scfu_pkg::PROD_W-1:0]  prod_q;
	logic                                fwd_q;

	// result register
	logic                                res_valid_q;
	logic signed [scfu_pkg::POS_W-1:0]   eye_x_q;
	logic signed [scfu_pkg::POS_W-1:0]   eye_y_q;
	logic signed [scfu_pkg::POS_W-1:0]   eye_z_q;
	logic signed [scfu_pkg::POS_W-1:0]   ctr_x_q;
	logic signed [scfu_pkg::POS_W-1:0]   ctr_y_q;
	logic signed [scfu_pkg::POS_W-1:0]   ctr_z_q;

	// datapath signals
	scfu_pkg::cordic_req_t               cor_req;
	scfu_pkg::cordic_rsp_t               cor_rsp;
	logic                                accept;
	logic                                out_load;
	logic signed [scfu_pkg::MUL_A_W-1:0] mul_a;
	logic signed [scfu_pkg::DIR_W-1:0]   mul_b;
	logic signed [scfu_pkg::PROD_W-1:0]  prod_d;
	logic signed [scfu_pkg::PROD_W-1:0]  rnd;
	logic signed [scfu_pkg::DD_W-1:0]    dd;
	logic signed [scfu_pkg::POS_W-1:0]   pos_cur;
	logic signed [scfu_pkg::SUM_W-1:0]   pos_sum;
	logic signed [scfu_pkg::POS_W-1:0]   pos_new;

	scfu_cordic u_cordic (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (cor_req),
		.rsp    (cor_rsp)
	);

	// configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			theta_step_q  <= scfu_pkg::THETA_STEP_RST;
			beta_step_q   <= scfu_pkg::BETA_STEP_RST;
			move_step_q   <= scfu_pkg::MOVE_STEP_RST;
			start_x_q     <= scfu_pkg::START_X_RST;
			start_y_q     <= scfu_pkg::START_Y_RST;
			start_z_q     <= scfu_pkg::START_Z_RST;
			start_theta_q <= scfu_pkg::START_THETA_RST;
			start_beta_q  <= scfu_pkg::START_BETA_RST;
		end else if (wr_en) begin
			case (scfu_pkg::cfg_reg_t'(wr_index))
				scfu_pkg::REG_THETA_STEP:  theta_step_q  <= wr_data[scfu_pkg::STEP_W-1:0];
				scfu_pkg::REG_BETA_STEP:   beta_step_q   <= wr_data[scfu_pkg::STEP_W-1:0];
				scfu_pkg::REG_MOVE_STEP:   move_step_q   <= wr_data[scfu_pkg::MSTEP_W-1:0];
				scfu_pkg::REG_START_X:     start_x_q     <= signed'(wr_data);
				scfu_pkg::REG_START_Y:     start_y_q     <= signed'(wr_data);
				scfu_pkg::REG_START_Z:     start_z_q     <= signed'(wr_data);
				scfu_pkg::REG_START_THETA: start_theta_q <= wr_data[scfu_pkg::STEP_W-1:0];
				scfu_pkg::REG_START_BETA:  start_beta_q  <= wr_data[scfu_pkg::STEP_W-1:0];
				default: ;
			endcase
		end
	end

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			scfu_pkg::ST_IDLE: begin
				if (cmd.valid) begin
					case (cmd.action)
						scfu_pkg::ACT_ORIENT,
						scfu_pkg::ACT_RESTART: state_d = scfu_pkg::ST_START_TH;
						scfu_pkg::ACT_MOVE:    state_d = scfu_pkg::ST_MOV_X;
						default:               state_d = scfu_pkg::ST_DONE;
					endcase
				end
			end
			scfu_pkg::ST_START_TH: state_d = scfu_pkg::ST_RUN_TH;
			scfu_pkg::ST_RUN_TH: begin
				if (cor_rsp.done)
					state_d = scfu_pkg::ST_RUN_BE;
			end
			scfu_pkg::ST_RUN_BE: begin
				if (cor_rsp.done)
					state_d = scfu_pkg::ST_DIR_X;
			end
			scfu_pkg::ST_DIR_X: state_d = scfu_pkg::ST_DIR_Z;
			scfu_pkg::ST_DIR_Z: state_d = scfu_pkg::ST_DIR_W;
			// the pass after reset returns no view item
			scfu_pkg::ST_DIR_W: state_d = init_q ? scfu_pkg::ST_IDLE : scfu_pkg::ST_DONE;
			scfu_pkg::ST_MOV_X: state_d = scfu_pkg::ST_MOV_Y;
			scfu_pkg::ST_MOV_Y: state_d = scfu_pkg::ST_MOV_Z;
			scfu_pkg::ST_MOV_Z: state_d = scfu_pkg::ST_MOV_W;
			scfu_pkg::ST_MOV_W: state_d = scfu_pkg::ST_DONE;
			scfu_pkg::ST_DONE: begin
				if (!res_valid_q || res.ready)
					state_d = scfu_pkg::ST_IDLE;
			end
			default: state_d = scfu_pkg::ST_IDLE;
		endcase
	end

	// sequencer outputs: handshakes, CORDIC start, multiplier operands
	always_comb begin
		cmd.ready     = (state_q == scfu_pkg::ST_IDLE);
		accept        = cmd.valid && (state_q == scfu_pkg::ST_IDLE);
		out_load      = (state_q == scfu_pkg::ST_DONE) && (!res_valid_q || res.ready);
		cor_req.start = 1'b0;
		cor_req.angle = polar_q;
		mul_a         = '0;
		mul_b         = '0;
		pos_cur       = pos_x_q;
		case (state_q)
			scfu_pkg::ST_START_TH: begin
				cor_req.start = 1'b1;
			end
			scfu_pkg::ST_RUN_TH: begin
				cor_req.start = cor_rsp.done;
				cor_req.angle = azim_q;
			end
			scfu_pkg::ST_DIR_X: begin
				mul_a = scfu_pkg::MUL_A_W'(st_q);
				mul_b = cb_q;
			end
			scfu_pkg::ST_DIR_Z: begin
				mul_a = scfu_pkg::MUL_A_W'(st_q);
				mul_b = sb_q;
			end
			scfu_pkg::ST_MOV_X: begin
				mul_a = signed'({1'b0, move_step_q});
				mul_b = dir_x_q;
			end
			scfu_pkg::ST_MOV_Y: begin
				mul_a   = signed'({1'b0, move_step_q});
				mul_b   = dir_y_q;
				pos_cur = pos_x_q;
			end
			scfu_pkg::ST_MOV_Z: begin
				mul_a   = signed'({1'b0, move_step_q});
				mul_b   = dir_z_q;
				pos_cur = pos_y_q;
			end
			scfu_pkg::ST_MOV_W: begin
				pos_cur = pos_z_q;
			end
			default: ;
		endcase
	end

	// shared multiplier, registered rounding and saturating position update
	always_comb begin
		prod_d  = scfu_pkg::PROD_W'(mul_a) * scfu_pkg::PROD_W'(mul_b);
		rnd     = (prod_q + scfu_pkg::PROD_W'(17'sd32768)) >>> 16;
		dd      = rnd[scfu_pkg::DD_W-1:0];
		if (fwd_q)
			pos_sum = scfu_pkg::SUM_W'(pos_cur) + scfu_pkg::SUM_W'(dd);
		else
			pos_sum = scfu_pkg::SUM_W'(pos_cur) - scfu_pkg::SUM_W'(dd);
		pos_new = scfu_pkg::sat32(pos_sum);
	end

	// control state and camera state that reset defines
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= scfu_pkg::ST_START_TH;
			init_q      <= 1'b1;
			res_valid_q <= 1'b0;
			polar_q     <= scfu_pkg::angle_fit(scfu_pkg::START_THETA_RST);
			azim_q      <= scfu_pkg::angle_fit(scfu_pkg::START_BETA_RST);
			pos_x_q     <= scfu_pkg::START_X_RST;
			pos_y_q     <= scfu_pkg::START_Y_RST;
			pos_z_q     <= scfu_pkg::START_Z_RST;
		end else begin
			state_q <= state_d;
			if (state_q == scfu_pkg::ST_DIR_W)
				init_q <= 1'b0;
			if (out_load)
				res_valid_q <= 1'b1;
			else if (res.ready)
				res_valid_q <= 1'b0;

			// command decode on acceptance
			if (accept) begin
				if (cmd.action == scfu_pkg::ACT_ORIENT) begin
					if (cmd.change_beta)
						azim_q <= cmd.beta_up ? azim_q + scfu_pkg::angle_fit(beta_step_q)
							: azim_q - scfu_pkg::angle_fit(beta_step_q);
					if (cmd.change_theta)
						polar_q <= cmd.theta_up ? polar_q + scfu_pkg::angle_fit(theta_step_q)
							: polar_q - scfu_pkg::angle_fit(theta_step_q);
				end else if (cmd.action == scfu_pkg::ACT_RESTART) begin
					polar_q <= scfu_pkg::angle_fit(start_theta_q);
					azim_q  <= scfu_pkg::angle_fit(start_beta_q);
					pos_x_q <= start_x_q;
					pos_y_q <= start_y_q;
					pos_z_q <= start_z_q;
				end
			end

			// move steps, one coordinate per cycle
			case (state_q)
				scfu_pkg::ST_MOV_Y: pos_x_q <= pos_new;
				scfu_pkg::ST_MOV_Z: pos_y_q <= pos_new;
				scfu_pkg::ST_MOV_W: pos_z_q <= pos_new;
				default: ;
			endcase
		end
	end

	// direction, trig capture and product registers
	always_ff @(posedge clk) begin
		if (accept)
			fwd_q <= cmd.forward;
		prod_q <= prod_d;
		case (state_q)
			scfu_pkg::ST_RUN_TH: begin
				if (cor_rsp.done) begin
					st_q    <= cor_rsp.sin;
					dir_y_q <= cor_rsp.cos;
				end
			end
			scfu_pkg::ST_RUN_BE: begin
				if (cor_rsp.done) begin
					sb_q <= cor_rsp.sin;
					cb_q <= cor_rsp.cos;
				end
			end
			scfu_pkg::ST_DIR_Z: dir_x_q <= rnd[scfu_pkg::DIR_W-1:0];
			scfu_pkg::ST_DIR_W: dir_z_q <= rnd[scfu_pkg::DIR_W-1:0];
			default: ;
		endcase
	end

	// view item: eye and saturated look-at point
	always_ff @(posedge clk) begin
		if (out_load) begin
			eye_x_q <= pos_x_q;
			eye_y_q <= pos_y_q;
			eye_z_q <= pos_z_q;
			ctr_x_q <= scfu_pkg::sat32(scfu_pkg::SUM_W'(pos_x_q) + scfu_pkg::SUM_W'(dir_x_q));
			ctr_y_q <= scfu_pkg::sat32(scfu_pkg::SUM_W'(pos_y_q) + scfu_pkg::SUM_W'(dir_y_q));
			ctr_z_q <= scfu_pkg::sat32(scfu_pkg::SUM_W'(pos_z_q) + scfu_pkg::SUM_W'(dir_z_q));
		end
	end

	assign res.valid    = res_valid_q;
	assign res.eye_x    = eye_x_q;
	assign res.eye_y    = eye_y_q;
	assign res.eye_z    = eye_z_q;
	assign res.center_x = ctr_x_q;
	assign res.center_y = ctr_y_q;
	assign res.center_z = ctr_z_q;

endmodule

// ===== tb/spherical_free_camera_update_unit_tb.sv =====
// ----------------------------------------------------------------------------
// spherical_free_camera_update_unit_tb
// Self-checking bench for the free-fly camera unit: a scripted opening of
// corner cases, then phases of random commands under fresh register settings.
// Every accepted command is run through a bit-exact camera model (CORDIC
// sine/cosine, rounded products, saturating sums) and the view item that
// comes back is compared field by field with the oldest prediction.
// ----------------------------------------------------------------------------
module spherical_free_camera_update_unit_tb;
	import scfu_pkg::*;

	localparam logic [1:0] ACT_UNUSED     = 2'd3;   // no-op code, view returned as is
	localparam int         ROTATIONS      = 18;
	localparam int         NUM_PHASES     = 7;
	localparam int         PHASE_ITEMS    = 250;
	localparam int         WATCHDOG_LIMIT = 4000;
	localparam int         TAIL_CYCLES    = 64;

	// arctangent of 2^-i in 2^-32 turns
	localparam logic [31:0] ATAN_TURNS [32] = '{
		32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4,
		32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
		32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
		32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D,
		32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
		32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051,
		32'h00000029, 32'h00000014, 32'h0000000A, 32'h00000005,
		32'h00000003, 32'h00000001, 32'h00000001, 32'h00000000
	};

	typedef struct packed {
		logic [1:0] action;
		logic       change_beta;
		logic       beta_up;
		logic       change_theta;
		logic       theta_up;
		logic       forward;
	} cam_cmd_t;

	typedef struct packed {
		logic signed [31:0] eye_x;
		logic signed [31:0] eye_y;
		logic signed [31:0] eye_z;
		logic signed [31:0] center_x;
		logic signed [31:0] center_y;
		logic signed [31:0] center_z;
	} view_t;

	// one line of the opening script: a register write or a command item,
	// the latter optionally with its eye point typed in
	typedef struct {
		logic               is_write;
		cfg_reg_t           idx;
		logic [31:0]        data;
		cam_cmd_t           c;
		logic               pinned;
		logic signed [31:0] pin_x;
		logic signed [31:0] pin_y;
		logic signed [31:0] pin_z;
	} script_row_t;

	logic                clk = 1'b0;
	logic                arst_n;
	logic                wr_en;
	cfg_reg_t            wr_index;
	logic [CFG_W-1:0]    wr_data;
	logic                sink_ready = 1'b0;

	scfu_cmd_if cmd_ch();
	scfu_res_if res_ch();

	assign res_ch.ready = sink_ready;

	spherical_free_camera_update_unit dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (wr_en),
		.wr_index (wr_index),
		.wr_data  (wr_data),
		.cmd      (cmd_ch),
		.res      (res_ch)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// camera model state and its copy of the registers
	logic [19:0]  theta_step, beta_step, start_polar, start_azim;
	logic [30:0]  move_step;
	logic [19:0]  polar, azim;
	longint       start_at [3];
	longint       eye_at [3];
	longint       sight [3];

	view_t        views_due [$];
	script_row_t  script [$];
	int unsigned  mismatches = 0;
	int unsigned  idle_cycles = 0;
	int unsigned  hold_off = 0;
	int unsigned  dice;
	logic         calm = 1'b0;

	function automatic longint clamp32(longint v);
		if (v > 64'sd2147483647)
			return 64'sd2147483647;
		if (v < -64'sd2147483648)
			return -64'sd2147483648;
		return v;
	endfunction

	// Q30 to Q16, half up, held to plus or minus one
	function automatic longint q16_round(longint v);
		longint r;
		r = (v + 64'sd8192) >>> 14;
		if (r > 64'sd65536)
			r = 64'sd65536;
		if (r < -64'sd65536)
			r = -64'sd65536;
		return r;
	endfunction

	function automatic longint round_mul(longint a, longint b);
		return (a * b + 64'sd32768) >>> 16;
	endfunction

	// quadrant split, then CORDIC rotation over the remaining quarter turn
	function automatic void cam_sin_cos(input logic [19:0] ang, output longint sn,
			output longint cs);
		logic [31:0] a32;
		longint      x, y, z, xs, ys, c, s;
		a32 = {ang, 12'd0};
		z = longint'(a32[29:0]);
		x = 64'sd652032874;
		y = 0;
		for (int i = 0; i < ROTATIONS; i++) begin
			xs = x >>> i;
			ys = y >>> i;
			if (z >= 0) begin
				x -= ys;
				y += xs;
				z -= longint'(ATAN_TURNS[i]);
			end else begin
				x += ys;
				y -= xs;
				z += longint'(ATAN_TURNS[i]);
			end
		end
		c = q16_round(x);
		s = q16_round(y);
		case (a32[31:30])
			2'd0: begin cs = c;  sn = s;  end
			2'd1: begin cs = -s; sn = c;  end
			2'd2: begin cs = -c; sn = -s; end
			default: begin cs = s;  sn = -c; end
		endcase
	endfunction

	function automatic void rebuild_sight();
		longint st, ct, sb, cb;
		cam_sin_cos(polar, st, ct);
		cam_sin_cos(azim, sb, cb);
		sight[0] = round_mul(st, cb);
		sight[1] = ct;
		sight[2] = round_mul(st, sb);
	endfunction

	// advances the camera model by one command and returns the view it yields
	function automatic view_t predict_view(cam_cmd_t c);
		view_t  v;
		longint delta;
		case (c.action)
			ACT_ORIENT: begin
				if (c.change_beta)
					azim = c.beta_up ? azim + beta_step : azim - beta_step;
				if (c.change_theta)
					polar = c.theta_up ? polar + theta_step : polar - theta_step;
				rebuild_sight();
			end
			ACT_MOVE: begin
				for (int k = 0; k < 3; k++) begin
					delta = round_mul(longint'(move_step), sight[k]);
					eye_at[k] = clamp32(c.forward ? eye_at[k] + delta : eye_at[k] - delta);
				end
			end
			ACT_RESTART: begin
				eye_at = start_at;
				polar = start_polar;
				azim = start_azim;
				rebuild_sight();
			end
			default: ;
		endcase
		v.eye_x = eye_at[0][31:0];
		v.eye_y = eye_at[1][31:0];
		v.eye_z = eye_at[2][31:0];
		v.center_x = 32'(clamp32(eye_at[0] + sight[0]));
		v.center_y = 32'(clamp32(eye_at[1] + sight[1]));
		v.center_z = 32'(clamp32(eye_at[2] + sight[2]));
		return v;
	endfunction

	function automatic script_row_t item_row(logic [1:0] act, logic [4:0] flags);
		script_row_t r;
		r.is_write = 1'b0;
		r.idx = REG_THETA_STEP;
		r.data = '0;
		r.c = {act, flags};
		r.pinned = 1'b0;
		r.pin_x = '0;
		r.pin_y = '0;
		r.pin_z = '0;
		return r;
	endfunction

	function automatic script_row_t pinned_row(logic [1:0] act, logic [4:0] flags,
			logic signed [31:0] x, logic signed [31:0] y, logic signed [31:0] z);
		script_row_t r;
		r = item_row(act, flags);
		r.pinned = 1'b1;
		r.pin_x = x;
		r.pin_y = y;
		r.pin_z = z;
		return r;
	endfunction

	function automatic script_row_t reg_row(cfg_reg_t idx, logic [31:0] data);
		script_row_t r;
		r = item_row(ACT_UNUSED, 5'b00000);
		r.is_write = 1'b1;
		r.idx = idx;
		r.data = data;
		return r;
	endfunction

	// register values for a random phase: mostly moderate, now and then an extreme
	function automatic logic [31:0] pick_setting(cfg_reg_t idx);
		int unsigned roll;
		logic [31:0] v;
		roll = $urandom_range(0, 9);
		case (idx)
			REG_THETA_STEP, REG_BETA_STEP:
				v = (roll == 0) ? 32'h0 : (roll == 1) ? 32'hFFFFF : $urandom_range(0, 32'h1FFFF);
			REG_START_THETA, REG_START_BETA:
				v = (roll == 0) ? 32'h0 : (roll == 1) ? 32'hFFFFF : $urandom_range(0, 32'hFFFFF);
			REG_MOVE_STEP:
				v = (roll == 0) ? 32'h0 : (roll == 1) ? 32'h7FFFFFFF :
					(roll < 4) ? $urandom_range(0, 32'h7FFFFFFF) : $urandom_range(0, 32'hFFFFFF);
			default:
				v = (roll == 0) ? 32'h80000000 : (roll == 1) ? 32'h7FFFFFFF :
					(roll < 4) ? $urandom() : $urandom_range(0, 32'h3FFFFFF) - 32'h1FFFFFF;
		endcase
		return v;
	endfunction

	function automatic void check_field(string name, logic signed [31:0] want,
			logic signed [31:0] got);
		if (want !== got) begin
			$error("%s: expected %0d, got %0d", name, want, got);
			mismatches++;
		end
	endfunction

	// sender gap: usually none, sometimes short, rarely long
	function automatic int unsigned pick_gap();
		int unsigned roll;
		roll = $urandom_range(0, 99);
		if (calm || roll < 70)
			return 0;
		if (roll < 95)
			return $urandom_range(1, 4);
		return $urandom_range(20, 80);
	endfunction

	// offer one command item, predict its view once taken
	task automatic send(script_row_t r);
		view_t       v;
		int unsigned gap;
		wr_en <= 1'b0;
		cmd_ch.valid <= 1'b1;
		cmd_ch.action <= r.c.action;
		cmd_ch.change_beta <= r.c.change_beta;
		cmd_ch.beta_up <= r.c.beta_up;
		cmd_ch.change_theta <= r.c.change_theta;
		cmd_ch.theta_up <= r.c.theta_up;
		cmd_ch.forward <= r.c.forward;
		do @(posedge clk); while (!cmd_ch.ready);
		v = predict_view(r.c);
		if (r.pinned) begin
			v.eye_x = r.pin_x;
			v.eye_y = r.pin_y;
			v.eye_z = r.pin_z;
		end
		views_due.push_back(v);
		gap = pick_gap();
		if (gap > 0) begin
			cmd_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	// stop offering and wait for every outstanding view
	task automatic settle();
		cmd_ch.valid <= 1'b0;
		while (views_due.size() != 0)
			@(posedge clk);
	endtask

	// write enable is left high; the next command item drops it
	task automatic write_register(cfg_reg_t idx, logic [31:0] d);
		wr_en <= 1'b1;
		wr_index <= idx;
		wr_data <= d;
		@(posedge clk);
		case (idx)
			REG_THETA_STEP:  theta_step = d[19:0];
			REG_BETA_STEP:   beta_step = d[19:0];
			REG_MOVE_STEP:   move_step = d[30:0];
			REG_START_X:     start_at[0] = longint'($signed(d));
			REG_START_Y:     start_at[1] = longint'($signed(d));
			REG_START_Z:     start_at[2] = longint'($signed(d));
			REG_START_THETA: start_polar = d[19:0];
			REG_START_BETA:  start_azim = d[19:0];
			default: ;
		endcase
	endtask

	// result side: random stalls, short and long, none in calm stretches
	always @(posedge clk) begin
		if (calm) begin
			sink_ready <= 1'b1;
			hold_off = 0;
		end else if (hold_off > 0) begin
			hold_off--;
			sink_ready <= 1'b0;
		end else begin
			dice = $urandom_range(0, 99);
			if (dice < 75) begin
				sink_ready <= 1'b1;
			end else begin
				sink_ready <= 1'b0;
				hold_off = (dice < 96) ? $urandom_range(0, 3) : $urandom_range(15, 70);
			end
		end
	end

	// compare each view item with the oldest prediction; watchdog on progress
	always @(posedge clk) begin
		view_t want;
		if (arst_n && res_ch.valid && res_ch.ready) begin
			if (views_due.size() == 0) begin
				$error("view item with no command outstanding");
				mismatches++;
			end else begin
				want = views_due.pop_front();
				check_field("eye_x", want.eye_x, res_ch.eye_x);
				check_field("eye_y", want.eye_y, res_ch.eye_y);
				check_field("eye_z", want.eye_z, res_ch.eye_z);
				check_field("center_x", want.center_x, res_ch.center_x);
				check_field("center_y", want.center_y, res_ch.center_y);
				check_field("center_z", want.center_z, res_ch.center_z);
			end
		end
		if ((cmd_ch.valid && cmd_ch.ready) || (res_ch.valid === 1'b1 && res_ch.ready))
			idle_cycles = 0;
		else
			idle_cycles++;
		if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("TB_ERROR");
			$finish;
		end
	end

	initial begin
		int unsigned roll;
		logic [1:0]  act;

		arst_n = 1'b0;
		wr_en = 1'b0;
		wr_index = REG_THETA_STEP;
		wr_data = '0;
		cmd_ch.valid = 1'b0;
		cmd_ch.action = ACT_ORIENT;
		cmd_ch.change_beta = 1'b0;
		cmd_ch.beta_up = 1'b0;
		cmd_ch.change_theta = 1'b0;
		cmd_ch.theta_up = 1'b0;
		cmd_ch.forward = 1'b0;

		// model at reset
		theta_step = 20'd16689;
		beta_step = 20'd16689;
		move_step = 31'd458752;
		start_at = '{64'sd0, 64'sd1310720, 64'sd4587520};
		start_polar = 20'd784519;
		start_azim = 20'd269979;
		eye_at = start_at;
		polar = start_polar;
		azim = start_azim;
		rebuild_sight();

		// opening script: reset state, each operation, then both register extremes
		script.push_back(pinned_row(ACT_UNUSED, 5'b11111, 32'sd0, 32'sd1310720, 32'sd4587520));
		script.push_back(item_row(ACT_ORIENT, 5'b00000));
		script.push_back(item_row(ACT_ORIENT, 5'b11000));
		script.push_back(item_row(ACT_ORIENT, 5'b10000));
		script.push_back(item_row(ACT_ORIENT, 5'b00110));
		script.push_back(item_row(ACT_ORIENT, 5'b00100));
		script.push_back(item_row(ACT_ORIENT, 5'b11110));
		script.push_back(item_row(ACT_ORIENT, 5'b10100));
		script.push_back(item_row(ACT_MOVE, 5'b00001));
		script.push_back(item_row(ACT_MOVE, 5'b11110));
		script.push_back(pinned_row(ACT_RESTART, 5'b00000, 32'sd0, 32'sd1310720, 32'sd4587520));
		script.push_back(reg_row(REG_THETA_STEP, 32'hFFFFF));
		script.push_back(reg_row(REG_BETA_STEP, 32'h0));
		script.push_back(reg_row(REG_MOVE_STEP, 32'h7FFFFFFF));
		script.push_back(reg_row(REG_START_X, 32'h7FFFFFFF));
		script.push_back(reg_row(REG_START_Y, 32'h80000000));
		script.push_back(reg_row(REG_START_Z, 32'h0));
		script.push_back(reg_row(REG_START_THETA, 32'hFFFFF));
		script.push_back(reg_row(REG_START_BETA, 32'h0));
		script.push_back(pinned_row(ACT_RESTART, 5'b00000, 32'h7FFFFFFF, 32'h80000000, 32'sd0));
		// full-scale moves saturate the position both ways
		script.push_back(item_row(ACT_MOVE, 5'b00001));
		script.push_back(item_row(ACT_MOVE, 5'b00001));
		script.push_back(item_row(ACT_MOVE, 5'b00000));
		script.push_back(item_row(ACT_MOVE, 5'b00000));
		// angle wraps past a full turn
		script.push_back(item_row(ACT_ORIENT, 5'b00110));
		script.push_back(item_row(ACT_ORIENT, 5'b10000));
		script.push_back(item_row(ACT_ORIENT, 5'b00100));
		script.push_back(reg_row(REG_START_THETA, 32'h0));
		script.push_back(reg_row(REG_START_BETA, 32'hFFFFF));
		script.push_back(reg_row(REG_THETA_STEP, 32'h0));
		script.push_back(reg_row(REG_BETA_STEP, 32'hFFFFF));
		script.push_back(reg_row(REG_MOVE_STEP, 32'h0));
		script.push_back(reg_row(REG_START_X, 32'h80000000));
		script.push_back(reg_row(REG_START_Y, 32'h7FFFFFFF));
		script.push_back(reg_row(REG_START_Z, 32'h80000000));
		script.push_back(pinned_row(ACT_RESTART, 5'b00000, 32'h80000000, 32'h7FFFFFFF,
			32'h80000000));
		script.push_back(pinned_row(ACT_ORIENT, 5'b11110, 32'h80000000, 32'h7FFFFFFF,
			32'h80000000));
		script.push_back(pinned_row(ACT_MOVE, 5'b00001, 32'h80000000, 32'h7FFFFFFF,
			32'h80000000));
		script.push_back(pinned_row(ACT_UNUSED, 5'b00000, 32'h80000000, 32'h7FFFFFFF,
			32'h80000000));

		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (script[k]) begin
			if (script[k].is_write) begin
				settle();
				write_register(script[k].idx, script[k].data);
			end else begin
				send(script[k]);
			end
		end

		// random phases, each under a fresh set of registers
		for (int p = 0; p < NUM_PHASES; p++) begin
			settle();
			calm = (p == 3);
			for (int i = 0; i < 8; i++)
				write_register(cfg_reg_t'(i), pick_setting(cfg_reg_t'(i)));
			for (int n = 0; n < PHASE_ITEMS; n++) begin
				if ($urandom_range(0, 79) == 0)
					settle();
				roll = $urandom_range(0, 99);
				act = (roll < 45) ? ACT_ORIENT : (roll < 85) ? ACT_MOVE :
					(roll < 94) ? ACT_RESTART : ACT_UNUSED;
				send(item_row(act, 5'($urandom_range(0, 31))));
			end
		end
		calm = 1'b0;

		settle();
		repeat (TAIL_CYCLES) @(posedge clk);
		if (mismatches == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

endmodule
